// ----- rtl/core/ata_pkg.sv -----
// ata_pkg: widths, pipeline depths, side-band type and the arctangent table
// shared by the tilt-angle front end, its cells and the top level
// no dependencies
package ata_pkg;

   // channel payload widths
   localparam int IN_W = 16;
   localparam int OUT_W = 14;

   // angle format
   localparam int ANGLE_FRAC_BITS = 6;
   localparam int ACC_FRAC = 20;
   localparam int ROUND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam int ANGLE_LIMIT = 90 << ANGLE_FRAC_BITS;

   // cordic rotation chain, bounded by the arctangent table length
   localparam int CORDIC_STAGES = 16;
   localparam int TAB_LEN = 24;
   localparam int CORDIC_N = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;
   localparam int TAB_IDX_W = 5;
   localparam int VEC_W = 35;
   localparam int ACC_W = 29;

   // normalization front end
   localparam int FRONT_STAGES = 6;
   localparam int NORM_STEPS = 31;
   localparam int NORM_TOP = 60;
   localparam int K_W = 5;
   localparam int SQ_IN_W = 32;
   localparam int AX_SQ_W = 31;

   // square root chain, one result bit per cell
   localparam int SQ_W = 64;
   localparam int SQRT_STAGES = 32;
   localparam int SQ_IDX_W = 5;
   localparam int SQ_TOP = 62;
   localparam int ROOT_W = 32;

   // total register stages ahead of the output register
   localparam int PIPE_N = FRONT_STAGES + SQRT_STAGES + CORDIC_N;

   // per-item flags that ride along with the datapath
   typedef struct packed {
      logic neg;
      logic zero;
   } ata_side_type;

   // atan(2^-i) in degrees scaled by 2^ACC_FRAC
   function automatic logic signed [ACC_W-1:0] ata_atan_deg(input logic [TAB_IDX_W-1:0] idx);
      logic signed [ACC_W-1:0] val;
      case (idx)
         5'd0:    val = 29'sd47185920;
         5'd1:    val = 29'sd27855475;
         5'd2:    val = 29'sd14718068;
         5'd3:    val = 29'sd7471121;
         5'd4:    val = 29'sd3750058;
         5'd5:    val = 29'sd1876857;
         5'd6:    val = 29'sd938658;
         5'd7:    val = 29'sd469357;
         5'd8:    val = 29'sd234682;
         5'd9:    val = 29'sd117342;
         5'd10:   val = 29'sd58671;
         5'd11:   val = 29'sd29335;
         5'd12:   val = 29'sd14668;
         5'd13:   val = 29'sd7334;
         5'd14:   val = 29'sd3667;
         5'd15:   val = 29'sd1833;
         5'd16:   val = 29'sd917;
         5'd17:   val = 29'sd458;
         5'd18:   val = 29'sd229;
         5'd19:   val = 29'sd115;
         5'd20:   val = 29'sd57;
         5'd21:   val = 29'sd29;
         5'd22:   val = 29'sd14;
         5'd23:   val = 29'sd7;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- rtl/core/ata_if.sv -----
// ata_req_if / ata_rsp_if: valid-ready channels for sample triples and angles
// depends on ata_pkg for payload widths
interface ata_req_if;
   logic valid;
   logic ready;
   logic signed [ata_pkg::IN_W-1:0] accel_x;
   logic signed [ata_pkg::IN_W-1:0] accel_y;
   logic signed [ata_pkg::IN_W-1:0] accel_z;

   modport source(output valid, output accel_x, output accel_y, output accel_z, input ready);
   modport sink(input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

interface ata_rsp_if;
   logic valid;
   logic ready;
   logic signed [ata_pkg::OUT_W-1:0] pitch_angle;

   modport source(output valid, output pitch_angle, input ready);
   modport sink(input valid, input pitch_angle, output ready);
endinterface

// ----- rtl/core/ata_front.sv -----
// ata_front: six-stage front end, absolute value, squares, magnitude sum and
// normalizing shift of the sample triple; depends on ata_pkg
module ata_front (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [ata_pkg::IN_W-1:0]     src_x,
   input  logic signed [ata_pkg::IN_W-1:0]     src_y,
   input  logic signed [ata_pkg::IN_W-1:0]     src_z,
   output logic [ata_pkg::SQ_W-1:0]            dst_rem,
   output logic [ata_pkg::ROOT_W-1:0]          dst_vy,
   output ata_pkg::ata_side_type               dst_side
);
   localparam int IN_W = ata_pkg::IN_W;
   localparam int SQ_W = ata_pkg::SQ_W;
   localparam int K_W = ata_pkg::K_W;
   localparam int NSTEP = ata_pkg::NORM_STEPS;
   localparam int SQ_IN_W = ata_pkg::SQ_IN_W;
   localparam int AX_SQ_W = ata_pkg::AX_SQ_W;
   localparam int ROOT_W = ata_pkg::ROOT_W;
   localparam int VY_WIDE_W = IN_W + (1 << K_W);

   // stage a: magnitude of x, flags
   logic [IN_W-1:0]            ax_a_ff, ax_a_in;
   logic signed [IN_W-1:0]     y_a_ff, z_a_ff;
   ata_pkg::ata_side_type      side_a_ff, side_a_in;
   // stage b: squares
   logic [AX_SQ_W-1:0]         ax2_b_ff, y2_b_ff, z2_b_ff;
   logic [AX_SQ_W-1:0]         ax2_b_in, y2_b_in, z2_b_in;
   logic [IN_W-1:0]            ax_b_ff;
   ata_pkg::ata_side_type      side_b_ff;
   logic signed [2*IN_W-1:0]   y_prod, z_prod;
   logic [2*IN_W-1:0]          ax_prod;
   // stage c: sum of squares
   logic [SQ_IN_W-1:0]         s_c_ff, s_c_in;
   logic [AX_SQ_W-1:0]         ax2_c_ff;
   logic [IN_W-1:0]            ax_c_ff;
   ata_pkg::ata_side_type      side_c_ff;
   // stage d: larger square against the shift thresholds
   logic [NSTEP-1:0]           therm_d_ff, therm_d_in;
   logic [SQ_IN_W-1:0]         s_d_ff, m_w;
   logic [IN_W-1:0]            ax_d_ff;
   ata_pkg::ata_side_type      side_d_ff;
   // stage e: shift count
   logic [K_W-1:0]             k_e_ff, k_e_in;
   logic [SQ_IN_W-1:0]         s_e_ff;
   logic [IN_W-1:0]            ax_e_ff;
   ata_pkg::ata_side_type      side_e_ff;
   // stage f: normalized radicand and x leg
   logic [SQ_W-1:0]            rem_f_ff, rem_f_in;
   logic [ROOT_W-1:0]          vy_f_ff, vy_f_in;
   logic [VY_WIDE_W-1:0]       vy_wide;
   ata_pkg::ata_side_type      side_f_ff;

   // absolute value of x
   assign ax_a_in = src_x[IN_W-1] ? (~src_x + 1'b1) : src_x;
   assign side_a_in.neg = src_x[IN_W-1];
   assign side_a_in.zero = (src_x == '0);

   // squares, one multiplier each
   assign ax_prod = ax_a_ff * ax_a_ff;
   assign y_prod = y_a_ff * y_a_ff;
   assign z_prod = z_a_ff * z_a_ff;
   assign ax2_b_in = ax_prod[AX_SQ_W-1:0];
   assign y2_b_in = y_prod[AX_SQ_W-1:0];
   assign z2_b_in = z_prod[AX_SQ_W-1:0];

   // horizontal magnitude squared
   assign s_c_in = SQ_IN_W'(y2_b_ff) + SQ_IN_W'(z2_b_ff);

   // thermometer of thresholds the larger square stays under
   assign m_w = (s_c_ff > SQ_IN_W'(ax2_c_ff)) ? s_c_ff : SQ_IN_W'(ax2_c_ff);
   always_comb begin
      for (int j = 0; j < NSTEP; j++) begin
         therm_d_in[j] = (SQ_W'(m_w) <= (SQ_W'(1) << (ata_pkg::NORM_TOP - 2 * j)));
      end
   end

   // thermometer to binary count through its edge
   always_comb begin
      logic edge_bit;
      k_e_in = '0;
      for (int j = 0; j < NSTEP; j++) begin
         if (j == NSTEP - 1) begin
            edge_bit = therm_d_ff[j];
         end else begin
            edge_bit = therm_d_ff[j] & ~therm_d_ff[j+1];
         end
         if (edge_bit) begin
            k_e_in = k_e_in | K_W'(j + 1);
         end
      end
   end

   // common left shift, twice as far for the squared term
   assign rem_f_in = SQ_W'(s_e_ff) << {k_e_ff, 1'b0};
   assign vy_wide = VY_WIDE_W'(ax_e_ff) << k_e_ff;
   assign vy_f_in = vy_wide[ROOT_W-1:0];

   // stage registers, all held while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         ax_a_ff <= ax_a_in;
         y_a_ff <= src_y;
         z_a_ff <= src_z;
         side_a_ff <= side_a_in;

         ax2_b_ff <= ax2_b_in;
         y2_b_ff <= y2_b_in;
         z2_b_ff <= z2_b_in;
         ax_b_ff <= ax_a_ff;
         side_b_ff <= side_a_ff;

         s_c_ff <= s_c_in;
         ax2_c_ff <= ax2_b_ff;
         ax_c_ff <= ax_b_ff;
         side_c_ff <= side_b_ff;

         therm_d_ff <= therm_d_in;
         s_d_ff <= s_c_ff;
         ax_d_ff <= ax_c_ff;
         side_d_ff <= side_c_ff;

         k_e_ff <= k_e_in;
         s_e_ff <= s_d_ff;
         ax_e_ff <= ax_d_ff;
         side_e_ff <= side_d_ff;

         rem_f_ff <= rem_f_in;
         vy_f_ff <= vy_f_in;
         side_f_ff <= side_e_ff;
      end
   end

   assign dst_rem = rem_f_ff;
   assign dst_vy = vy_f_ff;
   assign dst_side = side_f_ff;

endmodule

// ----- rtl/core/ata_sqrt_cell.sv -----
// ata_sqrt_cell: one digit step of the restoring integer square root,
// passing remainder, partial root and side-band to the next cell; uses ata_pkg
module ata_sqrt_cell (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [ata_pkg::SQ_IDX_W-1:0]        stage,
   input  logic [ata_pkg::SQ_W-1:0]            src_rem,
   input  logic [ata_pkg::SQ_W-1:0]            src_res,
   input  logic [ata_pkg::ROOT_W-1:0]          src_vy,
   input  ata_pkg::ata_side_type               src_side,
   output logic [ata_pkg::SQ_W-1:0]            dst_rem,
   output logic [ata_pkg::SQ_W-1:0]            dst_res,
   output logic [ata_pkg::ROOT_W-1:0]          dst_vy,
   output ata_pkg::ata_side_type               dst_side
);
   localparam int SQ_W = ata_pkg::SQ_W;
   localparam int SH_W = ata_pkg::SQ_IDX_W + 2;

   logic [SQ_W-1:0]            bit_w, trial_w;
   logic                       fits_w;
   logic [SQ_W-1:0]            rem_ff, rem_in, res_ff, res_in;
   logic [ata_pkg::ROOT_W-1:0] vy_ff;
   ata_pkg::ata_side_type      side_ff;

   // digit weight for this cell, two bit places per step
   assign bit_w = SQ_W'(1) << (SH_W'(ata_pkg::SQ_TOP) - SH_W'({stage, 1'b0}));
   assign trial_w = src_res + bit_w;
   assign fits_w = (src_rem >= trial_w);

   // subtract the trial when it fits and set this root bit
   assign rem_in = fits_w ? (src_rem - trial_w) : src_rem;
   assign res_in = fits_w ? ((src_res >> 1) + bit_w) : (src_res >> 1);

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         vy_ff <= src_vy;
         side_ff <= src_side;
      end
   end

   assign dst_rem = rem_ff;
   assign dst_res = res_ff;
   assign dst_vy = vy_ff;
   assign dst_side = side_ff;

endmodule

// ----- rtl/core/ata_cordic_cell.sv -----
// ata_cordic_cell: one vectoring micro-rotation, rotating toward the positive
// axis and summing the rotation angle in degrees; uses ata_pkg
module ata_cordic_cell (
   input  logic                                clock,
   input  logic                                advance,
   input  logic [ata_pkg::TAB_IDX_W-1:0]       stage,
   input  logic signed [ata_pkg::VEC_W-1:0]    src_vx,
   input  logic signed [ata_pkg::VEC_W-1:0]    src_vy,
   input  logic signed [ata_pkg::ACC_W-1:0]    src_acc,
   input  ata_pkg::ata_side_type               src_side,
   output logic signed [ata_pkg::VEC_W-1:0]    dst_vx,
   output logic signed [ata_pkg::VEC_W-1:0]    dst_vy,
   output logic signed [ata_pkg::ACC_W-1:0]    dst_acc,
   output ata_pkg::ata_side_type               dst_side
);
   localparam int VEC_W = ata_pkg::VEC_W;
   localparam int ACC_W = ata_pkg::ACC_W;

   logic signed [VEC_W-1:0]    dx_w, dy_w;
   logic signed [ACC_W-1:0]    ang_w;
   logic signed [VEC_W-1:0]    vx_ff, vx_in, vy_ff, vy_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   ata_pkg::ata_side_type      side_ff;

   // shifted legs, flooring toward minus infinity
   assign dx_w = src_vy >>> stage;
   assign dy_w = src_vx >>> stage;
   assign ang_w = ata_pkg::ata_atan_deg(stage);

   // rotate clockwise while y is not negative
   always_comb begin
      if (!src_vy[VEC_W-1]) begin
         vx_in = src_vx + dx_w;
         vy_in = src_vy - dy_w;
         acc_in = src_acc + ang_w;
      end else begin
         vx_in = src_vx - dx_w;
         vy_in = src_vy + dy_w;
         acc_in = src_acc - ang_w;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         acc_ff <= acc_in;
         side_ff <= src_side;
      end
   end

   assign dst_vx = vx_ff;
   assign dst_vy = vy_ff;
   assign dst_acc = acc_ff;
   assign dst_side = side_ff;

endmodule

// ----- rtl/core/accel_tilt_angle.sv -----
// accel_tilt_angle: pitch angle atan2(x, sqrt(y*y+z*z)) of one accelerometer
// sample triple; depends on ata_pkg, ata_if, ata_front, ata_sqrt_cell and
// ata_cordic_cell
//
// Usage: a sample triple (accel_x, accel_y, accel_z) is taken on req_chan at
// every clock edge where valid and ready are both high. One angle leaves on
// rsp_chan for each triple, in order, as pitch_angle in 1/64 degree steps,
// rounded to nearest and limited to +-90 degrees; a zero x sample gives 0.
// From the input transfer to rsp valid a triple passes six front-end
// stages (absolute value, squares, sum, normalizing shift), a row of 32
// square-root cells, one bit each, a row of 16 CORDIC rotation cells and the
// rounding output register. The cell rows are fully pipelined, so unless
// stalled, a new triple is taken every cycle and throughput is one result
// per cycle. When the receiver holds off, the result waits in the output
// register and the pipeline keeps moving as long as its last stage is empty;
// once a finished item sits behind the waiting one, the whole row holds and
// req ready drops. Reset clears all valid bits; nothing is in flight after.
module accel_tilt_angle (
   input  logic          clock,
   input  logic          reset,
   ata_req_if.sink       req_chan,
   ata_rsp_if.source     rsp_chan
);
   localparam int SQ_W = ata_pkg::SQ_W;
   localparam int ROOT_W = ata_pkg::ROOT_W;
   localparam int VEC_W = ata_pkg::VEC_W;
   localparam int ACC_W = ata_pkg::ACC_W;
   localparam int OUT_W = ata_pkg::OUT_W;
   localparam int SQ_N = ata_pkg::SQRT_STAGES;
   localparam int CR_N = ata_pkg::CORDIC_N;
   localparam int PIPE_N = ata_pkg::PIPE_N;
   localparam int SQ_IDX_W = ata_pkg::SQ_IDX_W;
   localparam int TAB_IDX_W = ata_pkg::TAB_IDX_W;

   // pipeline control
   logic [PIPE_N-1:0]          pv_ff, pv_in;
   logic                       out_valid_ff, out_valid_in;
   logic                       out_free, advance;

   // cell row links
   logic [SQ_W-1:0]            sq_rem [SQ_N+1];
   logic [SQ_W-1:0]            sq_res [SQ_N+1];
   logic [ROOT_W-1:0]          sq_vy [SQ_N+1];
   ata_pkg::ata_side_type      sq_side [SQ_N+1];
   logic signed [VEC_W-1:0]    cr_vx [CR_N+1];
   logic signed [VEC_W-1:0]    cr_vy [CR_N+1];
   logic signed [ACC_W-1:0]    cr_acc [CR_N+1];
   ata_pkg::ata_side_type      cr_side [CR_N+1];

   // rounding
   logic [ACC_W-1:0]           acc_pos, acc_rnd, q_w, q_lim;
   logic [OUT_W-1:0]           angle_w;
   logic signed [OUT_W-1:0]    pitch_ff, pitch_in;

   // stall only when a finished item is stuck behind a waiting result
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign advance = out_free || !pv_ff[PIPE_N-1];
   assign req_chan.ready = advance;

   ata_front u_front (
      .clock    (clock),
      .advance  (advance),
      .src_x    (req_chan.accel_x),
      .src_y    (req_chan.accel_y),
      .src_z    (req_chan.accel_z),
      .dst_rem  (sq_rem[0]),
      .dst_vy   (sq_vy[0]),
      .dst_side (sq_side[0])
   );
   assign sq_res[0] = '0;

   // square root row
   for (genvar g = 0; g < SQ_N; g++) begin : g_sqrt
      ata_sqrt_cell u_cell (
         .clock    (clock),
         .advance  (advance),
         .stage    (SQ_IDX_W'(g)),
         .src_rem  (sq_rem[g]),
         .src_res  (sq_res[g]),
         .src_vy   (sq_vy[g]),
         .src_side (sq_side[g]),
         .dst_rem  (sq_rem[g+1]),
         .dst_res  (sq_res[g+1]),
         .dst_vy   (sq_vy[g+1]),
         .dst_side (sq_side[g+1])
      );
   end

   // vector (r, |x|) enters the rotation row
   assign cr_vx[0] = VEC_W'(sq_res[SQ_N][ROOT_W-1:0]);
   assign cr_vy[0] = VEC_W'(sq_vy[SQ_N]);
   assign cr_acc[0] = '0;
   assign cr_side[0] = sq_side[SQ_N];

   // cordic rotation row
   for (genvar g = 0; g < CR_N; g++) begin : g_cordic
      ata_cordic_cell u_cell (
         .clock    (clock),
         .advance  (advance),
         .stage    (TAB_IDX_W'(g)),
         .src_vx   (cr_vx[g]),
         .src_vy   (cr_vy[g]),
         .src_acc  (cr_acc[g]),
         .src_side (cr_side[g]),
         .dst_vx   (cr_vx[g+1]),
         .dst_vy   (cr_vy[g+1]),
         .dst_acc  (cr_acc[g+1]),
         .dst_side (cr_side[g+1])
      );
   end

   // round to the output step, limit to 90 degrees, apply the sign of x
   assign acc_pos = cr_acc[CR_N][ACC_W-1] ? '0 : ACC_W'(cr_acc[CR_N]);
   assign acc_rnd = acc_pos + (ACC_W'(1) << (ata_pkg::ROUND_SH - 1));
   assign q_w = acc_rnd >> ata_pkg::ROUND_SH;
   assign q_lim = (q_w > ACC_W'(ata_pkg::ANGLE_LIMIT)) ? ACC_W'(ata_pkg::ANGLE_LIMIT) : q_w;
   assign angle_w = cr_side[CR_N].neg ? (~q_lim[OUT_W-1:0] + 1'b1) : q_lim[OUT_W-1:0];
   assign pitch_in = cr_side[CR_N].zero ? '0 : angle_w;

   // valid bits follow the items down the row
   assign pv_in = {pv_ff[PIPE_N-2:0], req_chan.valid};
   assign out_valid_in = pv_ff[PIPE_N-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            pv_ff <= pv_in;
         end
         if (out_free) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   // output register, loaded whenever the previous result has gone
   always_ff @(posedge clock) begin
      if (out_free) begin
         pitch_ff <= pitch_in;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.pitch_angle = pitch_ff;

endmodule

// ----- verif/tb_top.sv -----
// tb_top: self-checking bench for accel_tilt_angle, the pitch angle of one sample triple
// depends on ata_pkg, the ata_req_if / ata_rsp_if channels and the accel_tilt_angle rtl
// an in-bench angle predictor fills a queue that the result monitor checks in order
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 70;
   localparam int HOLD_LEN = 300;
   localparam int IDLE_PCT = 37;

   // atan(2^-i) in degrees, 20 fractional bits
   localparam longint ATAN_STEP [24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7
   };

   logic clock;
   logic reset;

   ata_req_if req_bus ();
   ata_rsp_if rsp_bus ();

   accel_tilt_angle u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus.sink),
      .rsp_chan (rsp_bus.source)
   );

   logic signed [ata_pkg::OUT_W-1:0] pitch_expected [$];
   int mismatch_count = 0;
   int cycle_count = 0;
   bit send_idle_on;
   bit recv_stall_on;
   int hold_req_count = 0;
   int hold_seen_count = 0;
   int hold_left = 0;

   // clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // integer square root, bit by bit
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > n) probe = probe >> 2;
      while (probe != 0) begin
         if (n >= root + probe) begin
            n = n - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   // expected pitch angle of one triple, 1/64 degree steps
   function automatic logic signed [ata_pkg::OUT_W-1:0] pitch_predict(
      input logic signed [ata_pkg::IN_W-1:0] x,
      input logic signed [ata_pkg::IN_W-1:0] y,
      input logic signed [ata_pkg::IN_W-1:0] z
   );
      longint sx, sy, sz;
      longint unsigned ax, horiz_sq, peak, top;
      int k;
      longint vx, vy, dx, dy, acc, q, lim;
      int rsh;
      sx = x;
      sy = y;
      sz = z;
      rsh = ata_pkg::ACC_FRAC - ata_pkg::ANGLE_FRAC_BITS;
      lim = longint'(90) << ata_pkg::ANGLE_FRAC_BITS;
      ax = (sx < 0) ? -sx : sx;
      horiz_sq = sy * sy + sz * sz;
      if (ax == 0) return '0;
      // normalize so the larger of |x| and r sits near 2^31
      peak = ax * ax;
      if (horiz_sq > peak) peak = horiz_sq;
      top = 64'd1 << 62;
      k = 0;
      while (k < 31 && peak <= (top >> (2 * (k + 1)))) k++;
      vx = root_floor(horiz_sq << (2 * k));
      vy = ax << k;
      acc = 0;
      // vectoring rotations toward the positive axis
      for (int i = 0; i < ata_pkg::CORDIC_STAGES && i < 24; i++) begin
         dx = vy >>> i;
         dy = vx >>> i;
         if (vy >= 0) begin
            vx = vx + dx;
            vy = vy - dy;
            acc = acc + ATAN_STEP[i];
         end else begin
            vx = vx - dx;
            vy = vy + dy;
            acc = acc - ATAN_STEP[i];
         end
      end
      // round half away from zero, limit to 90 degrees, apply sign of x
      if (acc < 0) acc = 0;
      q = (acc + (longint'(1) << (rsh - 1))) >>> rsh;
      if (q > lim) q = lim;
      if (sx < 0) q = -q;
      return q[ata_pkg::OUT_W-1:0];
   endfunction

   // one triple transfer on the request channel, with optional idle cycles ahead
   task automatic push_sample(
      input logic signed [ata_pkg::IN_W-1:0] x,
      input logic signed [ata_pkg::IN_W-1:0] y,
      input logic signed [ata_pkg::IN_W-1:0] z
   );
      while (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.accel_x <= x;
      req_bus.accel_y <= y;
      req_bus.accel_z <= z;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pitch_expected.push_back(pitch_predict(x, y, z));
   endtask

   // one random axis sample, mixing full range, small, extreme and zero values
   function automatic logic signed [ata_pkg::IN_W-1:0] rand_axis();
      int v;
      int sel;
      sel = $urandom_range(9);
      case (sel)
         0, 1, 2, 3, 4: v = $urandom;
         5:             v = int'($urandom_range(16)) - 8;
         6: begin
            case ($urandom_range(4))
               0:       v = -32768;
               1:       v = 32767;
               2:       v = -32767;
               3:       v = 1;
               default: v = -1;
            endcase
         end
         7:             v = 0;
         default:       v = int'($urandom_range(2047)) - 1024;
      endcase
      return v[ata_pkg::IN_W-1:0];
   endfunction

   // random triples, sometimes followed by the mirrored x
   task automatic push_random(input int count);
      logic signed [ata_pkg::IN_W-1:0] x, y, z;
      for (int n = 0; n < count; n++) begin
         x = rand_axis();
         y = rand_axis();
         z = rand_axis();
         push_sample(x, y, z);
         if ($urandom_range(7) == 0) push_sample(-x, y, z);
      end
   endtask

   // result monitor and receiver ready
   always @(posedge clock) begin
      logic signed [ata_pkg::OUT_W-1:0] want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pitch_expected.size() == 0) begin
               $display("%0t: unexpected pitch_angle %0d, nothing pending",
                        $time, rsp_bus.pitch_angle);
               mismatch_count++;
            end else begin
               want = pitch_expected.pop_front();
               if (rsp_bus.pitch_angle !== want) begin
                  $display("%0t: pitch_angle mismatch, expected %0d, actual %0d",
                           $time, want, rsp_bus.pitch_angle);
                  mismatch_count++;
               end
            end
         end
         // long hold-off on request, otherwise random stalls
         if (hold_req_count != hold_seen_count) begin
            hold_seen_count <= hold_req_count;
            hold_left <= HOLD_LEN;
            rsp_bus.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_bus.ready <= 1'b0;
         end else if (recv_stall_on) begin
            rsp_bus.ready <= ($urandom_range(99) >= IDLE_PCT);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // extremes, zero x, zero y and z, symmetry and a few known angles
   task automatic test_directed();
      send_idle_on = 1'b0;
      recv_stall_on = 1'b0;
      push_sample(16'sd0, 16'sd0, 16'sd0);
      push_sample(16'sd0, 16'sd32767, -16'sd32768);
      push_sample(16'sd0, -16'sd32768, -16'sd32768);
      push_sample(16'sd1, 16'sd0, 16'sd0);
      push_sample(-16'sd1, 16'sd0, 16'sd0);
      push_sample(16'sd32767, 16'sd0, 16'sd0);
      push_sample(-16'sd32768, 16'sd0, 16'sd0);
      push_sample(16'sd32767, 16'sd32767, 16'sd32767);
      push_sample(-16'sd32768, -16'sd32768, -16'sd32768);
      push_sample(-16'sd32768, 16'sd32767, -16'sd32768);
      push_sample(16'sd1, 16'sd32767, 16'sd32767);
      push_sample(-16'sd1, -16'sd32768, -16'sd32768);
      push_sample(16'sd100, 16'sd100, 16'sd0);
      push_sample(-16'sd100, 16'sd0, 16'sd100);
      push_sample(16'sd23170, 16'sd16384, 16'sd16384);
      push_sample(16'sd1, 16'sd1, 16'sd0);
      push_sample(-16'sd1, 16'sd0, -16'sd1);
      push_sample(16'sd32767, 16'sd1, 16'sd0);
      push_sample(16'sd3, 16'sd4, 16'sd0);
      push_sample(16'sd12345, -16'sd2222, 16'sd777);
      push_sample(-16'sd12345, -16'sd2222, 16'sd777);
      push_sample(-16'sd21846, 16'sd5461, -16'sd10923);
      push_sample(16'sd21846, 16'sd5461, -16'sd10923);
   endtask

   // random triples with idle cycles on both sides
   task automatic test_random_idle();
      send_idle_on = 1'b1;
      recv_stall_on = 1'b1;
      push_random(1000);
   endtask

   // random triples back to back, no idling anywhere
   task automatic test_random_streaming();
      send_idle_on = 1'b0;
      recv_stall_on = 1'b0;
      push_random(270);
   endtask

   // receiver holds off while the sender keeps offering, so req ready drops
   task automatic test_backpressure();
      send_idle_on = 1'b0;
      recv_stall_on = 1'b0;
      hold_req_count <= hold_req_count + 1;
      push_random(130);
      send_idle_on = 1'b1;
      recv_stall_on = 1'b1;
      push_random(60);
   endtask

   // reset, tests, drain and verdict
   initial begin
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.accel_x <= '0;
      req_bus.accel_y <= '0;
      req_bus.accel_z <= '0;
      send_idle_on = 1'b0;
      recv_stall_on = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_idle();
      test_random_streaming();
      test_backpressure();

      req_bus.valid <= 1'b0;
      while (pitch_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/ata_pkg.sv
rtl/core/ata_if.sv
rtl/core/ata_front.sv
rtl/core/ata_sqrt_cell.sv
rtl/core/ata_cordic_cell.sv
rtl/core/accel_tilt_angle.sv
verif/tb_top.sv
